@@ rtl/mmt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the macro modulation table.
// No dependencies; imported by the table core.
package mmt_pkg;

  // Command codes carried on the input channel.
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Status codes returned with each result.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd2;

  // Macro level of 1.0 in Q1.16.
  localparam logic [16:0] MACRO_ONE = 17'd65536;

  // Saturation limits of a Q8.16 value.
  localparam logic signed [23:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] VAL_MIN = 24'sh800000;

  // Sequencer states, one-hot.
  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_SCAN   = 13'b0000000000010,
    ST_CHK    = 13'b0000000000100,
    ST_MULA   = 13'b0000000001000,
    ST_MULB   = 13'b0000000010000,
    ST_MULC   = 13'b0000000100000,
    ST_ACC    = 13'b0000001000000,
    ST_RND    = 13'b0000010000000,
    ST_FIN    = 13'b0000100000000,
    ST_SHRD   = 13'b0001000000000,
    ST_SHWR   = 13'b0010000000000,
    ST_APPEND = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_t;

endpackage

@@ rtl/macro_modulation_table_core.sv @@
`timescale 1ns / 1ps
// Macro modulation table: ordered assignment table, sequencer and shared multiplier.
// Depends on mmt_pkg for command, status and state codes.
//
// Usage:
//   Commands arrive on the in_ channel (valid/ready); one result per command leaves
//   on the out_ channel (valid/ready). The macro level is written through the cfg_
//   channel, which is always ready; values above 1.0 are clamped to 1.0.
//   The table lives in a single-port-write, registered-read memory. A lookup walks
//   the table from the first entry, reading and then comparing each entry visited,
//   then runs the shared multiplier: three products, accumulate, round, sum and
//   completion for range mode, and one product, round, sum and completion for
//   offset mode. A miss ends once the last stored entry is compared. An add
//   searches the same way; on a match it shifts the later entries down over the
//   matching one, and then it appends if there is room. A remove shifts from the
//   given index; a clear zeroes the entry count. The memory port sets the pace:
//   one entry is read or moved at a time.
//   in_ready is high only while the sequencer is idle; one command is in work at
//   a time. A finished result waits in the output register, and the next command
//   can already be taken; if the receiver stalls, that command completes and then
//   holds until the output register frees up.
//   Reset empties the table (count zero), zeroes the macro level and drops out_valid;
//   no clearing pass is needed.
module macro_modulation_table_core #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_BITS     = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [16:0]               cfg_macro_level,
  // Command channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_command,
  input  logic [ID_BITS-1:0]        in_param_id,
  input  logic signed [23:0]        in_base_value,
  input  logic signed [15:0]        in_amount,
  input  logic                      in_use_range,
  input  logic signed [23:0]        in_range_min,
  input  logic signed [23:0]        in_range_max,
  input  logic [4:0]                in_remove_index,
  // Result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [23:0]        out_modulated_value,
  output logic                      out_found,
  output logic [4:0]                out_entry_count,
  output logic [1:0]                out_status
);
  import mmt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic signed [15:0] amt;
    logic               rng;
    logic signed [23:0] lo;
    logic signed [23:0] hi;
  } entry_t;

  // Table memory and its registered read port.
  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_data_r;
  logic               mem_we;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;
  entry_t             mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Control state.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [16:0]        macro_r, macro_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Latched command.
  cmd_t               cmd_r, cmd_nxt;
  entry_t             new_r, new_nxt;
  logic signed [23:0] base_r, base_nxt;

  // Lookup arithmetic.
  logic signed [23:0] from_r, from_nxt;
  logic signed [24:0] span_r, span_nxt;
  logic [16:0]        absamt_r, absamt_nxt;
  logic signed [15:0] amt_r, amt_nxt;
  logic               rng_r, rng_nxt;
  logic signed [43:0] prod_r, prod_nxt;
  logic signed [40:0] p1_r, p1_nxt;
  logic signed [57:0] acc_r, acc_nxt;
  logic signed [27:0] rnd_r, rnd_nxt;

  // Result being built and the output register.
  logic signed [23:0] val_r, val_nxt;
  logic               found_r, found_nxt;
  logic [1:0]         status_r, status_nxt;
  logic signed [23:0] oval_r, oval_nxt;
  logic               ofound_r, ofound_nxt;
  logic [4:0]         ocount_r, ocount_nxt;
  logic [1:0]         ostatus_r, ostatus_nxt;

  // Shared multiplier operands.
  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [43:0] mul_p;

  // Helper terms.
  logic [CNT_W-1:0]   idx_p1;
  logic [CMP_W-1:0]   ridx_ext;
  logic [CMP_W-1:0]   used_ext;
  logic               id_match;
  logic               ent_neg;
  logic signed [24:0] ent_lo_w;
  logic signed [24:0] ent_hi_w;
  logic signed [57:0] prod_ext;
  logic signed [43:0] off_rnd;
  logic signed [28:0] fin_sum;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);

  assign idx_p1   = idx_r + CNT_W'(1);
  assign ridx_ext = CMP_W'(in_remove_index);
  assign used_ext = CMP_W'(used_r);
  assign id_match = (rd_data_r.id == new_r.id);
  assign ent_neg  = rd_data_r.amt[15];
  assign ent_lo_w = {rd_data_r.lo[23], rd_data_r.lo};
  assign ent_hi_w = {rd_data_r.hi[23], rd_data_r.hi};
  assign prod_ext = {{14{prod_r[43]}}, prod_r};
  assign off_rnd  = prod_r + 44'sd8192;
  assign fin_sum  = {{5{from_r[23]}}, from_r} + {rnd_r[27], rnd_r};
  assign out_free = !out_valid_r || out_ready;

  // Shared multiplier: operands chosen by the sequencer step.
  always_comb begin
    mul_a = span_r[24] ? {1'b1, span_r} : {1'b0, span_r};
    mul_b = {1'b0, absamt_r};
    case (state_r)
      ST_MULA: begin
        if (rng_r) begin
          mul_a = {span_r[24], span_r};
          mul_b = {1'b0, absamt_r};
        end else begin
          mul_a = {{10{amt_r[15]}}, amt_r};
          mul_b = {1'b0, macro_r};
        end
      end
      ST_MULB: begin
        mul_a = {6'd0, prod_r[19:0]};
        mul_b = {1'b0, macro_r};
      end
      ST_MULC: begin
        mul_a = {{5{p1_r[40]}}, p1_r[40:20]};
        mul_b = {1'b0, macro_r};
      end
      default: begin
        mul_a = {span_r[24], span_r};
        mul_b = {1'b0, absamt_r};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    macro_nxt     = macro_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_nxt       = cmd_r;
    new_nxt       = new_r;
    base_nxt      = base_r;
    from_nxt      = from_r;
    span_nxt      = span_r;
    absamt_nxt    = absamt_r;
    amt_nxt       = amt_r;
    rng_nxt       = rng_r;
    prod_nxt      = prod_r;
    p1_nxt        = p1_r;
    acc_nxt       = acc_r;
    rnd_nxt       = rnd_r;
    val_nxt       = val_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    oval_nxt      = oval_r;
    ofound_nxt    = ofound_r;
    ocount_nxt    = ocount_r;
    ostatus_nxt   = ostatus_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = idx_r[IDX_W-1:0];
    mem_raddr     = idx_r[IDX_W-1:0];
    mem_wdata     = rd_data_r;

    // Macro level register, clamped to 1.0.
    if (cfg_valid) begin
      macro_nxt = (cfg_macro_level > MACRO_ONE) ? MACRO_ONE : cfg_macro_level;
    end

    case (state_r)
      // Take a command and decide the first step.
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = cmd_t'(in_command);
          new_nxt.id  = in_param_id;
          new_nxt.amt = in_amount;
          new_nxt.rng = in_use_range;
          new_nxt.lo  = in_range_min;
          new_nxt.hi  = in_range_max;
          base_nxt    = in_base_value;
          val_nxt     = '0;
          found_nxt   = 1'b0;
          status_nxt  = STAT_OK;
          idx_nxt     = '0;
          case (cmd_t'(in_command))
            CMD_LOOKUP: begin
              if (used_r == '0) begin
                val_nxt   = in_base_value;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            CMD_ADD: begin
              state_nxt = (used_r == '0) ? ST_APPEND : ST_SCAN;
            end
            CMD_REMOVE: begin
              if (ridx_ext < used_ext) begin
                idx_nxt   = CNT_W'(ridx_ext);
                state_nxt = ST_SHRD;
              end else begin
                status_nxt = STAT_BAD_INDEX;
                state_nxt  = ST_DONE;
              end
            end
            default: begin
              used_nxt  = '0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // Read the entry under the scan pointer.
      ST_SCAN: begin
        mem_re    = 1'b1;
        state_nxt = ST_CHK;
      end

      // Compare the id; on a lookup hit, set up the arithmetic operands.
      ST_CHK: begin
        if (id_match) begin
          if (cmd_r == CMD_LOOKUP) begin
            found_nxt = 1'b1;
            amt_nxt   = rd_data_r.amt;
            rng_nxt   = rd_data_r.rng;
            if (rd_data_r.rng) begin
              from_nxt   = ent_neg ? rd_data_r.hi : rd_data_r.lo;
              span_nxt   = ent_neg ? (ent_lo_w - ent_hi_w) : (ent_hi_w - ent_lo_w);
              absamt_nxt = ent_neg ? 17'(-{rd_data_r.amt[15], rd_data_r.amt})
                                   : {1'b0, rd_data_r.amt};
            end else begin
              from_nxt = base_r;
            end
            state_nxt = ST_MULA;
          end else begin
            state_nxt = ST_SHRD;
          end
        end else if (idx_p1 == used_r) begin
          if (cmd_r == CMD_LOOKUP) begin
            val_nxt   = base_r;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_APPEND;
          end
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = ST_SCAN;
        end
      end

      // First product: span times depth, or macro times depth for offset mode.
      ST_MULA: begin
        prod_nxt  = mul_p;
        state_nxt = rng_r ? ST_MULB : ST_RND;
      end

      // Low half of the first product times the macro level.
      ST_MULB: begin
        p1_nxt    = prod_r[40:0];
        prod_nxt  = mul_p;
        state_nxt = ST_MULC;
      end

      // High half of the first product times the macro level.
      ST_MULC: begin
        acc_nxt   = prod_ext;
        prod_nxt  = mul_p;
        state_nxt = ST_ACC;
      end

      // Combine the two partial products and add the rounding half.
      ST_ACC: begin
        acc_nxt   = acc_r + (prod_ext <<< 20) + 58'sd536870912;
        state_nxt = ST_RND;
      end

      // Reduce to Q8.16.
      ST_RND: begin
        rnd_nxt   = rng_r ? acc_r[57:30] : off_rnd[41:14];
        state_nxt = ST_FIN;
      end

      // Add the start value and saturate.
      ST_FIN: begin
        if (fin_sum[28:23] != {6{fin_sum[28]}}) begin
          val_nxt = fin_sum[28] ? VAL_MIN : VAL_MAX;
        end else begin
          val_nxt = fin_sum[23:0];
        end
        state_nxt = ST_DONE;
      end

      // Delete at the pointer: read the next entry, or finish the shift.
      ST_SHRD: begin
        if (idx_p1 < used_r) begin
          mem_re    = 1'b1;
          mem_raddr = idx_p1[IDX_W-1:0];
          state_nxt = ST_SHWR;
        end else begin
          used_nxt  = used_r - CNT_W'(1);
          state_nxt = (cmd_r == CMD_ADD) ? ST_APPEND : ST_DONE;
        end
      end

      // Move the entry one place down.
      ST_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[IDX_W-1:0];
        mem_wdata = rd_data_r;
        idx_nxt   = idx_p1;
        state_nxt = ST_SHRD;
      end

      // Append the new entry unless the table is full.
      ST_APPEND: begin
        if (used_r >= CNT_W'(TABLE_DEPTH)) begin
          status_nxt = STAT_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = used_r[IDX_W-1:0];
          mem_wdata = new_r;
          used_nxt  = used_r + CNT_W'(1);
        end
        state_nxt = ST_DONE;
      end

      // Hand the result to the output register when it is free.
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          oval_nxt      = val_r;
          ofound_nxt    = found_r;
          ocount_nxt    = used_ext[4:0];
          ostatus_nxt   = status_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      idx_r       <= '0;
      macro_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      idx_r       <= idx_nxt;
      macro_r     <= macro_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    new_r     <= new_nxt;
    base_r    <= base_nxt;
    from_r    <= from_nxt;
    span_r    <= span_nxt;
    absamt_r  <= absamt_nxt;
    amt_r     <= amt_nxt;
    rng_r     <= rng_nxt;
    prod_r    <= prod_nxt;
    p1_r      <= p1_nxt;
    acc_r     <= acc_nxt;
    rnd_r     <= rnd_nxt;
    val_r     <= val_nxt;
    found_r   <= found_nxt;
    status_r  <= status_nxt;
    oval_r    <= oval_nxt;
    ofound_r  <= ofound_nxt;
    ocount_r  <= ocount_nxt;
    ostatus_r <= ostatus_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_modulated_value = oval_r;
  assign out_found           = ofound_r;
  assign out_entry_count     = ocount_r;
  assign out_status          = ostatus_r;

`ifndef NO_ASSERTIONS
  // The entry count never exceeds the table depth.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // A matched lookup always reports a good status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == STAT_OK))
    else $error("found result with bad status");

  // A clear leaves the table empty when its result is formed.
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && cmd_r == CMD_CLEAR) |-> (used_r == '0))
    else $error("clear left entries in the table");

  // A new result only appears out of the completion step.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside completion");
`endif

endmodule
